>>> hdl/plp_pkg.sv
// types and constants shared by the partitioned lag/lead window unit
// no dependencies; used by plp_front, plp_queue, plp_back and the top level
package plp_pkg;

  // fixed field widths
  localparam int unsigned VAL_W = 64;
  localparam int unsigned OFF_W = 5;
  // count width that covers a history of up to 64 rows
  localparam int unsigned CNT_W = 7;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 2'd2;

  // mode codes
  localparam logic MODE_LAG  = 1'b0;
  localparam logic MODE_LEAD = 1'b1;

  // one classified row: leading flush, own result, trailing flush
  typedef struct packed {
    logic [CNT_W-1:0] flush_a;
    logic             own_en;
    logic             own_dflt;
    logic             own_null;
    logic [VAL_W-1:0] own_val;
    logic [CNT_W-1:0] flush_b;
  } plp_cmd_t;

endpackage

>>> hdl/plp_front.sv
// front end: accepts rows, keeps history ring and partition counters,
// emits one plp_cmd_t per row; depends on plp_pkg
module plp_front #(
  parameter int unsigned MAX_OFFSET = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          partition_start_i,
  input  logic [plp_pkg::VAL_W-1:0]     row_value_i,
  input  logic                          row_is_null_i,
  input  logic                          end_of_stream_i,
  input  logic                          mode_i,
  input  logic [plp_pkg::OFF_W-1:0]     offset_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output plp_pkg::plp_cmd_t             cmd_o
);

  localparam int unsigned DEPTH = MAX_OFFSET + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // history ring, no reset
  logic [plp_pkg::VAL_W:0] hist_mem [DEPTH];
  logic [plp_pkg::VAL_W:0] rd_q;

  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] rows_q, rows_d;
  logic [CW-1:0] pend_q, pend_d;
  logic          seen_q, seen_d;

  // stage 1 registers
  logic                      s1_valid_q, s1_valid_d;
  logic [CW-1:0]             s1_flush_a_q, s1_flush_b_q;
  logic                      s1_own_en_q, s1_miss_q, s1_hist_q;
  logic [plp_pkg::VAL_W-1:0] s1_val_q;
  logic                      s1_null_q;

  logic          accept;
  logic          new_part;
  logic [CW-1:0] off;
  logic [AW-1:0] off_a;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] pend0, rows0, pinc, pend1, flush_a, flush_b;
  logic          own_en, miss, hist;

  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q;
  assign in_ready_o = !s1_valid_q || push_ready_i;

  // clamp offset to the ring reach
  assign off   = (32'(offset_i) > 32'(MAX_OFFSET)) ? CW'(MAX_OFFSET) : CW'(offset_i);
  assign off_a = AW'(off);

  // ring slot of the lag target
  assign rd_addr = (wp_q >= off_a) ? (wp_q - off_a) : (wp_q + AW'(DEPTH) - off_a);

  // classify the row
  always_comb begin
    new_part = partition_start_i || !seen_q;
    flush_a  = new_part ? pend_q : '0;
    pend0    = new_part ? '0 : pend_q;
    rows0    = new_part ? '0 : rows_q;
    pinc     = (pend0 < CW'(DEPTH)) ? (pend0 + CW'(1)) : pend0;
    own_en   = 1'b0;
    miss     = 1'b0;
    hist     = 1'b0;
    pend1    = pend0;
    if (mode_i == plp_pkg::MODE_LAG) begin
      own_en = 1'b1;
      miss   = off > rows0;
      hist   = off != '0;
    end else begin
      if (pinc > off) begin
        own_en = 1'b1;
        pend1  = pinc - CW'(1);
      end else begin
        pend1  = pinc;
      end
    end
    flush_b = end_of_stream_i ? pend1 : '0;
    pend_d  = end_of_stream_i ? '0 : pend1;
    seen_d  = !end_of_stream_i;
    wp_d    = (wp_q == AW'(DEPTH - 1)) ? '0 : (wp_q + AW'(1));
    rows_d  = (rows0 < CW'(DEPTH)) ? (rows0 + CW'(1)) : rows0;
  end

  assign s1_valid_d = accept ? 1'b1 : (push_ready_i ? 1'b0 : s1_valid_q);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      rows_q     <= '0;
      pend_q     <= '0;
      seen_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        wp_q   <= wp_d;
        rows_q <= rows_d;
        pend_q <= pend_d;
        seen_q <= seen_d;
      end
    end
  end

  // history ring write and registered target read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_mem[wp_q] <= {row_is_null_i, row_value_i};
      rd_q           <= hist_mem[rd_addr];
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flush_a_q <= flush_a;
      s1_flush_b_q <= flush_b;
      s1_own_en_q  <= own_en;
      s1_miss_q    <= miss;
      s1_hist_q    <= hist;
      s1_val_q     <= row_value_i;
      s1_null_q    <= row_is_null_i;
    end
  end

  // resolve own result from ring or current row
  always_comb begin
    logic                      src_null;
    logic [plp_pkg::VAL_W-1:0] src_val;
    src_null      = s1_hist_q ? rd_q[plp_pkg::VAL_W] : s1_null_q;
    src_val       = s1_hist_q ? rd_q[plp_pkg::VAL_W-1:0] : s1_val_q;
    cmd_o.flush_a = plp_pkg::CNT_W'(s1_flush_a_q);
    cmd_o.flush_b = plp_pkg::CNT_W'(s1_flush_b_q);
    cmd_o.own_en  = s1_own_en_q;
    cmd_o.own_dflt = s1_miss_q || src_null;
    cmd_o.own_null = !s1_miss_q && src_null;
    cmd_o.own_val  = src_val;
  end

endmodule

>>> hdl/plp_queue.sv
// two-entry command queue between front and back end
// depends on plp_pkg
module plp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  plp_pkg::plp_cmd_t push_cmd_i,
  output logic              head_valid_o,
  input  logic              pop_i,
  output plp_pkg::plp_cmd_t head_cmd_o
);

  plp_pkg::plp_cmd_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_cmd_o   = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> hdl/plp_back.sv
// back end: expands each command into result beats through an output register
// depends on plp_pkg
module plp_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  plp_pkg::plp_cmd_t         head_cmd_i,
  output logic                      pop_o,
  input  logic [plp_pkg::VAL_W-1:0] default_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [plp_pkg::VAL_W-1:0] result_value_o,
  output logic                      result_is_null_o,
  output logic                      last_of_run_o
);

  plp_pkg::plp_cmd_t cur_q, cur_d, src;
  logic busy_q, busy_d;

  logic                      out_valid_q, out_valid_d;
  logic [plp_pkg::VAL_W-1:0] out_val_q, out_val_d;
  logic                      out_null_q, out_null_d;
  logic                      out_last_q, out_last_d;

  logic src_v, has_beat, adv, step;
  logic [plp_pkg::VAL_W-1:0] beat_val;
  logic                      beat_null;

  assign src   = busy_q ? cur_q : head_cmd_i;
  assign src_v = busy_q || head_valid_i;
  assign adv   = !out_valid_q || out_ready_i;
  assign has_beat = (src.flush_a != '0) || src.own_en || (src.flush_b != '0);
  assign step  = src_v && (adv || !has_beat);
  assign pop_o = step && !busy_q;

  // pick next beat: leading flush, own result, trailing flush
  always_comb begin
    cur_d     = src;
    beat_val  = default_value_i;
    beat_null = 1'b0;
    priority if (src.flush_a != '0) begin
      cur_d.flush_a = src.flush_a - plp_pkg::CNT_W'(1);
    end else if (src.own_en) begin
      cur_d.own_en = 1'b0;
      beat_val     = src.own_dflt ? default_value_i : src.own_val;
      beat_null    = src.own_null;
    end else if (src.flush_b != '0) begin
      cur_d.flush_b = src.flush_b - plp_pkg::CNT_W'(1);
    end else begin
      cur_d = src;
    end
    out_last_d  = (cur_d.flush_a == '0) && !cur_d.own_en && (cur_d.flush_b == '0);
    busy_d      = step ? (has_beat && !out_last_d) : busy_q;
    out_valid_d = adv ? (step && has_beat) : out_valid_q;
    out_val_d   = beat_val;
    out_null_d  = beat_null;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (step) cur_q <= cur_d;
    if (adv && step && has_beat) begin
      out_val_q  <= out_val_d;
      out_null_q <= out_null_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = out_val_q;
  assign result_is_null_o = out_null_q;
  assign last_of_run_o    = out_last_q;

endmodule

>>> hdl/partitioned_lag_lead.sv
// Partitioned LAG/LEAD window unit. Rows enter on s_axis one per beat, sorted and
// partitioned; results leave on m_axis, tlast marking the final result of a row.
// A row whose work yields at most one result does not hold up the input, so rows
// stream at one per cycle while m_axis is not back-pressured; a row that closes a
// partition or the stream in lead mode yields one result per flushed pending row
// plus its own, written by the back-end sequencer at one beat a cycle while m_axis
// is ready. An input beat reaches the output through the history ring read, the
// command queue and the output register. Write mode, offset and default_value only while idle.
module partitioned_lag_lead #(
  parameter int unsigned MAX_OFFSET = 31
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // row input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [plp_pkg::VAL_W-1:0]         s_axis_tdata,  // row_value
  input  logic [1:0]                        s_axis_tuser,  // partition_start, row_is_null
  input  logic                              s_axis_tlast,  // end_of_stream
  // result output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [plp_pkg::VAL_W-1:0]         m_axis_tdata,  // result_value
  output logic [0:0]                        m_axis_tuser,  // result_is_null
  output logic                              m_axis_tlast,  // last_of_run
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [plp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [plp_pkg::VAL_W-1:0]         cfg_data_i
);

  logic                      mode_q;
  logic [plp_pkg::OFF_W-1:0] offset_q;
  logic [plp_pkg::VAL_W-1:0] default_q;

  logic              push, push_ready, head_valid, pop;
  plp_pkg::plp_cmd_t push_cmd, head_cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= plp_pkg::MODE_LAG;
      offset_q  <= plp_pkg::OFF_W'(1);
      default_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plp_pkg::CFG_MODE:    mode_q    <= cfg_data_i[0];
        plp_pkg::CFG_OFFSET:  offset_q  <= cfg_data_i[plp_pkg::OFF_W-1:0];
        plp_pkg::CFG_DEFAULT: default_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  plp_front #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .partition_start_i (s_axis_tuser[0]),
    .row_value_i       (s_axis_tdata),
    .row_is_null_i     (s_axis_tuser[1]),
    .end_of_stream_i   (s_axis_tlast),
    .mode_i            (mode_q),
    .offset_i          (offset_q),
    .push_o            (push),
    .push_ready_i      (push_ready),
    .cmd_o             (push_cmd)
  );

  plp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_cmd_o   (head_cmd)
  );

  plp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_cmd_i       (head_cmd),
    .pop_o            (pop),
    .default_value_i  (default_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .result_value_o   (m_axis_tdata),
    .result_is_null_o (m_axis_tuser[0]),
    .last_of_run_o    (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // front keeps pushing a command that a full queue has not taken
  a_push_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !push_ready) |=> push)
    else $error("front dropped a command while queue full");

  // flush counts never exceed the history depth
  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid |-> (32'(head_cmd.flush_a) <= MAX_OFFSET + 1) &&
                   (32'(head_cmd.flush_b) <= MAX_OFFSET + 1))
    else $error("flush count beyond history depth");

  // back end pops only an entry that is present
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule
